@@ rtl/core/pmp_ra_pkg.sv @@
// Package of shared types and constants for the protection region allocator.
package pmp_ra_pkg;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_RELEASE = 3'd1,
    OP_ENCODE  = 3'd2,
    OP_QUERY   = 3'd3,
    OP_OVERLAP = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_OVERLAP   = 3'd2,
    ST_UNALIGNED = 3'd3,
    ST_BAD_TOR   = 3'd4,
    ST_NO_SLOT   = 3'd5,
    ST_INVALID   = 3'd6
  } status_e;

  localparam logic [1:0] PRI_ANY    = 2'd0;
  localparam logic [1:0] PRI_TOP    = 2'd1;
  localparam logic [1:0] PRI_BOTTOM = 2'd2;

  localparam logic [7:0] CFG_TOR   = 8'h08;
  localparam logic [7:0] CFG_NAPOT = 8'h18;
  localparam logic [7:0] PERM_MASK = 8'h07;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  enclave;
    logic [63:0] start_address;
    logic [63:0] length;
    logic [1:0]  priority_req;
    logic        share_ok;
    logic [3:0]  region_select;
    logic [7:0]  permission;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_id;
    logic [3:0]  entry_index;
    logic [63:0] entry_address;
    logic [7:0]  entry_config;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic        overlaps;
    logic        last;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic scan_step; // compare one region for overlap
    logic scan_clr;  // clear the overlap scan
    logic commit;    // apply create or release
    logic emit0;     // build first result
    logic emit1;     // build second result
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic pair;
  } dp_sts_t;

endpackage

@@ rtl/core/pmp_ra_if.sv @@
// Valid/ready channel interface carrying one word.
interface pmp_ra_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

@@ rtl/core/pmp_ra_ctrl.sv @@
// Controller state machine sequencing the allocator datapath.
module pmp_ra_ctrl
  import pmp_ra_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    op_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_OUT1} state_e;

  state_e state_q, state_d;
  logic   vld_q, vld_d;

  assign in_ready_o  = (state_q == S_IDLE) && !vld_q;
  assign out_valid_o = vld_q;

  always_comb begin
    state_d = state_q;
    vld_d   = vld_q;
    cmd_o   = '0;
    if (vld_q && out_ready_i) begin
      vld_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !vld_q) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          if (op_valid_i) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.commit = 1'b1;
        cmd_o.emit0  = 1'b1;
        vld_d        = 1'b1;
        state_d      = sts_i.pair ? S_OUT1 : S_IDLE;
      end
      S_OUT1: begin
        if (out_ready_i) begin
          cmd_o.emit1 = 1'b1;
          vld_d       = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> vld_q)
    else $error("result not raised after execute");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !vld_q)
    else $error("input taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !out_ready_i) |=> vld_q)
    else $error("result dropped");

endmodule

@@ rtl/core/pmp_ra_dp.sv @@
// Datapath: region tables, entry-use maps, overlap scan and result build.
module pmp_ra_dp
  import pmp_ra_pkg::*;
#(
  parameter int REGIONS    = 16,
  parameter int ENTRIES    = 16,
  parameter int ENCLAVES   = 16,
  parameter int PAGE_SHIFT = 12
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output rsp_t    rsp_o
);

  localparam int RW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int EW = $clog2(ENTRIES);
  localparam int CW = $clog2(REGIONS + 1);
  localparam int NW = (ENCLAVES > 1) ? $clog2(ENCLAVES) : 1;
  localparam logic [63:0] PMASK = (64'd1 << PAGE_SHIFT) - 64'd1;
  localparam logic [63:0] ONES = '1;

  logic [63:0]   base_q   [REGIONS];
  logic [63:0]   len_q    [REGIONS];
  logic          napot_q  [REGIONS];
  logic          share_q  [REGIONS];
  logic [EW-1:0] ent_q    [REGIONS];
  logic [REGIONS-1:0]  valid_q;
  logic [ENTRIES-1:0]  use_q [ENCLAVES];

  req_t          req_q;
  logic [CW-1:0] scan_q;
  logic          ovl_q;
  rsp_t          rsp_q;

  // Request decode.
  logic          enc_ok, reg_ok, rvalid;
  logic [RW-1:0] rsel;
  logic [NW-1:0] eidx;
  logic [ENTRIES-1:0] map;
  logic [63:0]   st, ln, end_c;
  logic          wrap;
  assign st     = req_q.start_address;
  assign ln     = req_q.length;
  assign end_c  = st + ln;
  assign wrap   = end_c < st;
  assign enc_ok = 32'(req_q.enclave) < ENCLAVES;
  assign reg_ok = 32'(req_q.region_select) < REGIONS;
  assign rsel   = RW'(req_q.region_select);
  assign eidx   = NW'(req_q.enclave);
  assign rvalid = reg_ok && valid_q[rsel];
  assign map    = enc_ok ? use_q[eidx] : '1;

  // Free region and entry searches.
  logic          rfree_f, efree_f, pfree_f;
  logic [RW-1:0] rfree;
  logic [EW-1:0] efree, pfree;
  always_comb begin
    rfree_f = 1'b0; rfree = '0;
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin rfree_f = 1'b1; rfree = RW'(i); end
    end
    efree_f = 1'b0; efree = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!map[i]) begin efree_f = 1'b1; efree = EW'(i); end
    end
    pfree_f = 1'b0; pfree = '0;
    for (int i = ENTRIES - 2; i >= 0; i--) begin
      if (!map[i] && !map[i+1]) begin pfree_f = 1'b1; pfree = EW'(i + 1); end
    end
  end

  // Create decision.
  logic [2:0]    c_st;
  logic          c_napot, c_ok;
  logic [EW-1:0] c_ent;
  always_comb begin
    c_st    = ST_OK;
    c_ok    = 1'b0;
    c_ent   = '0;
    c_napot = (ln == ONES && st == 64'd0) ||
              (((ln & (ln - 64'd1)) == 64'd0) && ((st & (ln - 64'd1)) == 64'd0));
    if (ln == 64'd0) c_st = ST_BAD_SIZE;
    else if (!req_q.share_ok && (wrap || ovl_q)) c_st = ST_OVERLAP;
    else if ((ln != ONES && (ln & PMASK) != 64'd0) || (st & PMASK) != 64'd0)
      c_st = ST_UNALIGNED;
    else if (!c_napot && req_q.priority_req != PRI_ANY &&
             (req_q.priority_req != PRI_TOP || st != 64'd0)) c_st = ST_BAD_TOR;
    else if (!c_napot && (ln & PMASK) != 64'd0) c_st = ST_UNALIGNED;
    else if (!rfree_f) c_st = ST_NO_SLOT;
    else if (req_q.priority_req == PRI_TOP) begin
      if (map[0]) c_st = ST_NO_SLOT; else c_ok = 1'b1;
    end else if (c_napot && req_q.priority_req == PRI_BOTTOM) begin
      c_ent = EW'(ENTRIES - 1); c_ok = 1'b1;
    end else if (c_napot) begin
      if (!efree_f) c_st = ST_NO_SLOT; else begin c_ent = efree; c_ok = 1'b1; end
    end else begin
      if (!pfree_f) c_st = ST_NO_SLOT; else begin c_ent = pfree; c_ok = 1'b1; end
    end
  end
  logic c_rid_set;
  assign c_rid_set = (c_st == ST_OK) || (c_st == ST_NO_SLOT && rfree_f);

  // Encode values.
  logic [63:0] e_base, e_len, e_addr;
  logic        e_napot, e_pair;
  logic [EW-1:0] e_ent;
  assign e_base  = base_q[rsel];
  assign e_len   = len_q[rsel];
  assign e_napot = napot_q[rsel];
  assign e_ent   = ent_q[rsel];
  assign e_pair  = !e_napot && e_ent != '0;
  always_comb begin
    if (e_napot && e_base == 64'd0 && e_len == ONES) e_addr = ONES;
    else if (e_napot) e_addr = (e_base | ((e_len >> 1) - 64'd1)) >> 2;
    else e_addr = (e_base + e_len) >> 2;
  end

  assign sts_o.scan_done = scan_q == CW'(REGIONS - 1);
  assign sts_o.pair = (req_q.operation == OP_ENCODE) && rvalid && e_pair;
  assign rsp_o = rsp_q;

  // Scan one region per cycle.
  logic [RW-1:0] sidx;
  logic          scan_hit;
  assign sidx = scan_q[RW-1:0];
  assign scan_hit = valid_q[sidx] && !share_q[sidx] && base_q[sidx] < end_c &&
                    (base_q[sidx] + len_q[sidx]) > st;

  // Result word for the current emit command.
  rsp_t rsp_d;
  always_comb begin
    rsp_d      = '0;
    rsp_d.last = 1'b1;
    if (cmd_i.emit1) begin
      rsp_d.entry_index   = 4'(e_ent - EW'(1));
      rsp_d.entry_address = e_base >> 2;
    end else begin
      unique case (req_q.operation)
        OP_CREATE: begin
          rsp_d.status = c_st;
          if (c_rid_set) rsp_d.slot_id = 4'(rfree);
        end
        OP_OVERLAP: rsp_d.overlaps = wrap || ovl_q;
        default: begin
          if (!rvalid) rsp_d.status = ST_INVALID;
          else if (req_q.operation == OP_QUERY) begin
            rsp_d.region_base   = e_base;
            rsp_d.region_length = e_len;
          end else if (req_q.operation == OP_ENCODE) begin
            rsp_d.entry_index   = 4'(e_ent);
            rsp_d.entry_address = e_addr;
            rsp_d.entry_config  = (e_napot ? CFG_NAPOT : CFG_TOR) |
                                  (req_q.permission & PERM_MASK);
            rsp_d.last          = !e_pair;
          end
        end
      endcase
    end
  end

  // Entry-use row of the addressed enclave after a create or release.
  logic [ENTRIES-1:0] use_row;
  always_comb begin
    use_row = map;
    if (req_q.operation == OP_CREATE) begin
      use_row[c_ent] = 1'b1;
      if (!c_napot && c_ent != '0) use_row[c_ent - EW'(1)] = 1'b1;
    end else begin
      use_row[e_ent] = 1'b0;
      if (e_pair) use_row[e_ent - EW'(1)] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.scan_clr) begin
      scan_q <= '0; ovl_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (!sts_o.scan_done) scan_q <= scan_q + CW'(1);
      if (scan_hit) ovl_q <= 1'b1;
    end
    if (cmd_i.emit0 || cmd_i.emit1) rsp_q <= rsp_d;
    if (cmd_i.commit && req_q.operation == OP_CREATE && c_ok) begin
      base_q[rfree]  <= st;
      len_q[rfree]   <= ln;
      napot_q[rfree] <= c_napot;
      share_q[rfree] <= req_q.share_ok;
      ent_q[rfree]   <= c_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ENCLAVES; i++) use_q[i] <= '0;
    end else if (cmd_i.commit) begin
      if (req_q.operation == OP_CREATE && c_ok) begin
        valid_q[rfree] <= 1'b1;
        if (enc_ok) use_q[eidx] <= use_row;
      end else if (req_q.operation == OP_RELEASE && rvalid) begin
        valid_q[rsel] <= 1'b0;
        if (enc_ok) use_q[eidx] <= use_row;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_clr |=> (scan_q == '0 && !ovl_q))
    else $error("scan not cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && req_q.operation == OP_CREATE && c_ok) |=> valid_q[$past(rfree)])
    else $error("created region not marked valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit1 |=> (rsp_q.last && rsp_q.status == ST_OK))
    else $error("second encode word malformed");

endmodule

@@ rtl/core/pmp_region_allocator_unit.sv @@
// Top level of the protection region allocator.
//
//   channel  | dir | word   | accepted when
//   in_ch    | in  | req_t  | valid && ready
//   out_ch   | out | rsp_t  | valid && ready
//
// Every valid operation passes through a load step, an overlap scan (one
// region compared per cycle against the captured range) and an execute step
// that updates the tables and registers the first result word. A new request
// is taken only once the controller is idle again and no result word is
// pending. An encode of a TOR pair adds a second word once the first is taken.
// Undefined operation codes are accepted and dropped. Reset clears the valid
// map, the entry-use maps and the controller; table contents are written
// before use.
// A stalled output holds its word and blocks new input until it is taken.
module pmp_region_allocator_unit
  import pmp_ra_pkg::*;
#(
  parameter int REGIONS    = 16,
  parameter int ENTRIES    = 16,
  parameter int ENCLAVES   = 16,
  parameter int PAGE_SHIFT = 12
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pmp_ra_if.sink   in_ch,
  pmp_ra_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    op_valid;

  // Codes five to seven produce no word and touch no state.
  assign op_valid = in_ch.data.operation <= OP_OVERLAP;

  pmp_ra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .op_valid_i  (op_valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pmp_ra_dp #(
    .REGIONS    (REGIONS),
    .ENTRIES    (ENTRIES),
    .ENCLAVES   (ENCLAVES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_ch.data),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_ch.data)
  );

endmodule

@@ verif/pmp_ra_scoreboard.sv @@
// Checker that predicts the region allocator's result words and compares them.
module pmp_ra_scoreboard
  import pmp_ra_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  pmp_ra_if.monitor in_mon,
  pmp_ra_if.monitor out_mon,
  output int       fail_count_o,
  output int       pending_o
);

  localparam int NREG = 16;
  localparam int NENT = 16;
  localparam logic [63:0] PAGE_LOW = 64'hFFF;
  localparam logic [63:0] EVERYTHING = '1;

  logic [63:0] tbl_base [NREG];
  logic [63:0] tbl_len [NREG];
  logic        tbl_napot [NREG];
  logic        tbl_shared [NREG];
  logic [3:0]  tbl_entry [NREG];
  logic [NREG-1:0] region_live;
  logic [NENT-1:0] entries_used [16];

  rsp_t expected_words[$];
  int   fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_words.size();

  function automatic logic range_hits(logic [63:0] start, logic [63:0] len);
    logic [64:0] end65;
    logic [63:0] stop;
    end65 = {1'b0, start} + {1'b0, len};
    if (end65[64]) return 1'b1;
    stop = end65[63:0];
    for (int i = 0; i < NREG; i++) begin
      if (region_live[i] && !tbl_shared[i] &&
          tbl_base[i] < stop && tbl_base[i] + tbl_len[i] > start) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rsp_t blank_word();
    rsp_t w;
    w = '0;
    w.last = 1'b1;
    return w;
  endfunction

  // Create: returns the status and sets the chosen region.
  function automatic logic [2:0] do_create(req_t q, output logic [3:0] rid);
    logic napot;
    int r, ent;
    logic [NENT-1:0] map;
    map = entries_used[q.enclave];
    rid = '0;
    r = -1;
    ent = -1;
    if (q.length == 0) return ST_BAD_SIZE;
    if (!q.share_ok && range_hits(q.start_address, q.length)) return ST_OVERLAP;
    if ((q.length != EVERYTHING && (q.length & PAGE_LOW) != 0) ||
        (q.start_address & PAGE_LOW) != 0) return ST_UNALIGNED;
    napot = (q.length == EVERYTHING && q.start_address == 0) ||
            ((q.length & (q.length - 1)) == 0 &&
             (q.start_address & (q.length - 1)) == 0);
    if (!napot) begin
      if (q.priority_req != PRI_ANY &&
          (q.priority_req != PRI_TOP || q.start_address != 0)) return ST_BAD_TOR;
      if ((q.length & PAGE_LOW) != 0) return ST_UNALIGNED;
    end
    for (int i = 0; i < NREG; i++) if (r < 0 && !region_live[i]) r = i;
    if (r < 0) return ST_NO_SLOT;
    rid = r[3:0];
    if (napot) begin
      if (q.priority_req == PRI_TOP) begin
        if (map[0]) return ST_NO_SLOT;
        ent = 0;
      end else if (q.priority_req == PRI_BOTTOM) begin
        ent = NENT - 1;
      end else begin
        for (int i = 0; i < NENT; i++) if (ent < 0 && !map[i]) ent = i;
        if (ent < 0) return ST_NO_SLOT;
      end
    end else if (q.priority_req == PRI_TOP) begin
      if (map[0]) return ST_NO_SLOT;
      ent = 0;
    end else begin
      for (int i = 0; i + 1 < NENT; i++)
        if (ent < 0 && !map[i] && !map[i+1]) ent = i;
      if (ent < 0) return ST_NO_SLOT;
      ent = ent + 1;
    end
    tbl_base[r]   = q.start_address;
    tbl_len[r]    = q.length;
    tbl_napot[r]  = napot;
    tbl_shared[r] = q.share_ok;
    tbl_entry[r]  = ent[3:0];
    region_live[r] = 1'b1;
    entries_used[q.enclave][ent] = 1'b1;
    if (!napot && ent > 0) entries_used[q.enclave][ent-1] = 1'b1;
    return ST_OK;
  endfunction

  task automatic predict_words(req_t q);
    rsp_t w;
    logic [3:0] r, ent;
    logic [3:0] rid;
    logic pair;
    w = blank_word();
    r = q.region_select;
    case (q.operation)
      OP_CREATE: begin
        w.status = do_create(q, rid);
        w.slot_id = rid;
        expected_words.push_back(w);
      end
      OP_RELEASE, OP_ENCODE, OP_QUERY: begin
        if (!region_live[r]) begin
          w.status = ST_INVALID;
          expected_words.push_back(w);
        end else if (q.operation == OP_RELEASE) begin
          ent = tbl_entry[r];
          region_live[r] = 1'b0;
          entries_used[q.enclave][ent] = 1'b0;
          if (!tbl_napot[r] && ent > 0) entries_used[q.enclave][ent - 4'd1] = 1'b0;
          tbl_base[r] = '0; tbl_len[r] = '0; tbl_napot[r] = 1'b0;
          tbl_shared[r] = 1'b0; tbl_entry[r] = '0;
          expected_words.push_back(w);
        end else if (q.operation == OP_QUERY) begin
          w.region_base = tbl_base[r];
          w.region_length = tbl_len[r];
          expected_words.push_back(w);
        end else begin
          ent = tbl_entry[r];
          pair = !tbl_napot[r] && ent > 0;
          w.entry_index = ent;
          if (tbl_napot[r] && tbl_base[r] == 0 && tbl_len[r] == EVERYTHING)
            w.entry_address = EVERYTHING;
          else if (tbl_napot[r])
            w.entry_address = (tbl_base[r] | ((tbl_len[r] >> 1) - 64'd1)) >> 2;
          else
            w.entry_address = (tbl_base[r] + tbl_len[r]) >> 2;
          w.entry_config = (tbl_napot[r] ? CFG_NAPOT : CFG_TOR) |
                           (q.permission & PERM_MASK);
          w.last = !pair;
          expected_words.push_back(w);
          if (pair) begin
            w = blank_word();
            w.entry_index = ent - 4'd1;
            w.entry_address = tbl_base[r] >> 2;
            expected_words.push_back(w);
          end
        end
      end
      OP_OVERLAP: begin
        w.overlaps = range_hits(q.start_address, q.length);
        expected_words.push_back(w);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_w;
    if (!rst_ni) begin
      region_live <= '0;
      for (int i = 0; i < 16; i++) begin
        entries_used[i] <= '0;
        tbl_base[i] <= '0; tbl_len[i] <= '0; tbl_napot[i] <= 1'b0;
        tbl_shared[i] <= 1'b0; tbl_entry[i] <= '0;
      end
      fails <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          if (fails < 10) $display("unexpected word %p", out_mon.data);
          fails <= fails + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_mon.data !== exp_w) begin
            if (fails < 10) $display("mismatch exp %p got %p", exp_w, out_mon.data);
            fails <= fails + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) predict_words(in_mon.data);
    end
  end

endmodule

@@ verif/pmp_region_allocator_unit_tb.sv @@
// Testbench top: drives requests with random pacing and gives the verdict.
module pmp_region_allocator_unit_tb;
  import pmp_ra_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   sent;
  longint cycle_count;
  logic hold_off;

  pmp_ra_if #(.T(req_t)) in_ch ();
  pmp_ra_if #(.T(rsp_t)) out_ch ();

  pmp_region_allocator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  pmp_ra_scoreboard i_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch.monitor),
    .out_mon      (out_ch.monitor),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle watchdog. The limit leaves a wide margin over the slowest correct
  // run, receiver stalls included.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver stalls on its own random pattern, and once for a long
  // stretch while the sender keeps offering words.
  always @(posedge clk_i) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Long hold-off, counted in cycles here so that the block backs up.
  initial begin
    hold_off = 1'b0;
    wait (sent >= 700);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Mostly page-aligned powers of two from 2^12 to 2^63 so that creates
  // succeed and the tables fill; occasionally wild values.
  function automatic logic [63:0] pick_length();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'(($urandom_range(1, 40)) << 12);
      3: return 64'($urandom_range(0, 4));
      default: return 64'h1 << $urandom_range(12, 63);
    endcase
  endfunction

  function automatic logic [63:0] pick_start(logic [63:0] len);
    logic [63:0] s;
    case ($urandom_range(0, 7))
      0: return {$urandom, $urandom};
      1: return '0;
      2: return 64'($urandom_range(0, 255)) << 12;
      default: begin
        s = {$urandom, $urandom};
        if (len != 0 && (len & (len - 1)) == 0) s = s & ~(len - 1);
        return s & ~64'hFFF;
      end
    endcase
  endfunction

  function automatic req_t random_request();
    req_t q;
    q.operation     = 3'($urandom_range(0, 99) < 35 ? OP_CREATE :
                         $urandom_range(0, 7));
    if (q.operation == 3'd5 && $urandom_range(0, 1)) q.operation = OP_ENCODE;
    q.enclave       = 4'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1));
    q.length        = pick_length();
    q.start_address = pick_start(q.length);
    q.priority_req  = 2'($urandom_range(0, 9) < 6 ? PRI_ANY : $urandom_range(0, 3));
    q.share_ok      = ($urandom_range(0, 3) == 0);
    q.region_select = 4'($urandom);
    q.permission    = 8'($urandom);
    return q;
  endfunction

  function automatic req_t make_req(logic [2:0] op, logic [63:0] start,
                                    logic [63:0] len, logic [1:0] pri,
                                    logic share, logic [3:0] r);
    req_t q;
    q = '0;
    q.operation = op; q.start_address = start; q.length = len;
    q.priority_req = pri; q.share_ok = share; q.region_select = r;
    q.permission = 8'hFF;
    return q;
  endfunction

  // Offers one word and waits until the block takes it.
  task automatic send_word(req_t q);
    in_ch.valid <= 1'b1;
    in_ch.data  <= q;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(1, 6);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  req_t directed[$];

  initial begin
    int burst;
    rst_ni       = 1'b0;
    cycle_count  = 0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every operation, every status but no-slot, the everything region,
    // a TOR pair and its encode, a wrapping shared TOR, an undefined code.
    directed.push_back(make_req(OP_QUERY, 64'd0, 64'd0, PRI_ANY, 1'b0, 4'd0));
    directed.push_back(make_req(OP_CREATE, 64'd0, 64'd0, PRI_ANY, 1'b0, 4'd0));
    directed.push_back(make_req(OP_CREATE, 64'h1000, 64'h800, PRI_ANY, 1'b0, 4'd0));
    directed.push_back(make_req(OP_CREATE, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, PRI_TOP,
                                1'b1, 4'd0));
    directed.push_back(make_req(OP_CREATE, 64'h3000, 64'h3000, PRI_ANY, 1'b0, 4'd0));
    directed.push_back(make_req(OP_CREATE, 64'h3000, 64'h3000, PRI_BOTTOM, 1'b0, 4'd0));
    directed.push_back(make_req(OP_CREATE, 64'h8000, 64'h3000, PRI_ANY, 1'b0, 4'd0));
    directed.push_back(make_req(OP_CREATE, 64'h10000, 64'h10000, PRI_BOTTOM, 1'b0,
                                4'd0));
    directed.push_back(make_req(OP_CREATE, 64'hFFFF_FFFF_FFFF_F000, 64'h2000,
                                PRI_ANY, 1'b1, 4'd0));
    directed.push_back(make_req(OP_CREATE, 64'hFFFF_FFFF_FFFF_F000, 64'h2000,
                                PRI_ANY, 1'b0, 4'd0));
    directed.push_back(make_req(OP_CREATE, 64'h20000, 64'h1000, 2'd3, 1'b0, 4'd0));
    directed.push_back(make_req(OP_CREATE, 64'h40000, 64'h3000, 2'd3, 1'b0, 4'd0));
    for (int r = 0; r < 6; r++)
      directed.push_back(make_req(OP_ENCODE, 64'd0, 64'd0, PRI_ANY, 1'b0, 4'(r)));
    directed.push_back(make_req(OP_QUERY, 64'd0, 64'd0, PRI_ANY, 1'b0, 4'd2));
    directed.push_back(make_req(OP_OVERLAP, 64'h9000, 64'h1000, PRI_ANY, 1'b0, 4'd0));
    directed.push_back(make_req(OP_OVERLAP, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, PRI_ANY,
                                1'b0, 4'd0));
    directed.push_back(make_req(OP_RELEASE, 64'd0, 64'd0, PRI_ANY, 1'b0, 4'd1));
    directed.push_back(make_req(3'd7, 64'd0, 64'd0, PRI_ANY, 1'b0, 4'd0));
    directed.push_back(make_req(OP_RELEASE, 64'd0, 64'd0, PRI_ANY, 1'b0, 4'd15));
    foreach (directed[i]) send_word(directed[i]);
    idle_gap();

    // Random part in bursts; a long receiver hold-off midway fills the block.
    sent = 0;
    while (sent < 1300) begin
      burst = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) begin
        send_word(random_request());
        sent++;
        // Clear out the tables now and then so creates keep succeeding.
        if (sent % 97 == 0)
          for (int r = 0; r < 16; r++)
            send_word(make_req(OP_RELEASE, 64'd0, 64'd0, PRI_ANY, 1'b0, 4'(r)));
      end
      if (burst != 12) idle_gap();
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
